// ===== src/rpwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpwe_pkg
// Shared constants, codes and helper functions for the rectangle pixel
// write engine.
// ----------------------------------------------------------------------------
package rpwe_pkg;

  // Default geometry and address widths
  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned AddrBitsDefault  = 32;

  // Fixed register widths
  localparam int unsigned FbBaseBits   = 32;
  localparam int unsigned ScreenBits   = 12;
  localparam int unsigned PitchBits    = 14;
  localparam int unsigned FormatBits   = 3;
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned DataBits     = 32;
  localparam int unsigned BytesBits    = 3;
  localparam int unsigned ChanBits     = 8;

  // Configuration register indexes
  localparam logic [CfgIndexBits-1:0] CFG_FB_BASE       = 3'd0;
  localparam logic [CfgIndexBits-1:0] CFG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CfgIndexBits-1:0] CFG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CfgIndexBits-1:0] CFG_LINE_PITCH    = 3'd3;
  localparam logic [CfgIndexBits-1:0] CFG_PIXEL_FORMAT  = 3'd4;

  // Register reset values
  localparam logic [FbBaseBits-1:0] FB_BASE_RST       = 32'hE000_0000;
  localparam logic [ScreenBits-1:0] SCREEN_WIDTH_RST  = 12'd1024;
  localparam logic [ScreenBits-1:0] SCREEN_HEIGHT_RST = 12'd768;
  localparam logic [PitchBits-1:0]  LINE_PITCH_RST    = 14'd2048;

  // Pixel formats
  localparam logic [FormatBits-1:0] FMT_INDEXED8 = 3'd0;
  localparam logic [FormatBits-1:0] FMT_RGB555   = 3'd1;
  localparam logic [FormatBits-1:0] FMT_RGB565   = 3'd2;
  localparam logic [FormatBits-1:0] FMT_RGB888   = 3'd3;
  localparam logic [FormatBits-1:0] FMT_RGBA8888 = 3'd4;

  // Request modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Outline walk phases
  localparam logic [1:0] PH_TOP    = 2'd0;
  localparam logic [1:0] PH_BOTTOM = 2'd1;
  localparam logic [1:0] PH_LEFT   = 2'd2;
  localparam logic [1:0] PH_RIGHT  = 2'd3;

  // Bytes per pixel; unknown formats behave as rgb888
  function automatic logic [BytesBits-1:0] bytes_of(input logic [FormatBits-1:0] fmt);
    logic [BytesBits-1:0] nb;
    unique case (fmt)
      FMT_INDEXED8: nb = 3'd1;
      FMT_RGB555:   nb = 3'd2;
      FMT_RGB565:   nb = 3'd2;
      FMT_RGBA8888: nb = 3'd4;
      default:      nb = 3'd3;
    endcase
    return nb;
  endfunction

  // Pack a colour for the given format
  function automatic logic [DataBits-1:0] pack_colour(
    input logic [FormatBits-1:0] fmt,
    input logic [ChanBits-1:0]   r,
    input logic [ChanBits-1:0]   g,
    input logic [ChanBits-1:0]   b,
    input logic [ChanBits-1:0]   a
  );
    logic [DataBits-1:0] px;
    unique case (fmt)
      FMT_INDEXED8: px = {24'd0, b};
      FMT_RGB555:   px = {17'd0, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565:   px = {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_RGBA8888: px = {a, r, g, b};
      default:      px = {8'd0, r, g, b};
    endcase
    return px;
  endfunction

endpackage

// ===== src/rectangle_pixel_write_engine.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted request is registered in the walk stage register, then the
// address stage computes its result into the output register with a 13x14 multiply.
// Throughput: one request per cycle while the output is not stalled.
// Backpressure on the output stalls both stages; input ready drops only then.
// Reset: asynchronous, active low; engine idle, configuration registers at their defaults.
// ----------------------------------------------------------------------------
// rectangle_pixel_write_engine
// Walks a filled or outlined rectangle one candidate pixel per step request
// and issues clipped framebuffer writes with packed colour data.
// ----------------------------------------------------------------------------
module rectangle_pixel_write_engine #(
  parameter int unsigned COORD_BITS = rpwe_pkg::CoordBitsDefault,
  parameter int unsigned ADDR_BITS  = rpwe_pkg::AddrBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [rpwe_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [rpwe_pkg::CfgDataBits-1:0]  cfg_data_i,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [COORD_BITS-1:0]             rect_x_i,
  input  logic [COORD_BITS-1:0]             rect_y_i,
  input  logic [COORD_BITS-1:0]             rect_w_i,
  input  logic [COORD_BITS-1:0]             rect_h_i,
  input  logic [rpwe_pkg::ChanBits-1:0]     red_i,
  input  logic [rpwe_pkg::ChanBits-1:0]     green_i,
  input  logic [rpwe_pkg::ChanBits-1:0]     blue_i,
  input  logic [rpwe_pkg::ChanBits-1:0]     alpha_i,
  input  logic                              filled_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              write_valid_o,
  output logic [rpwe_pkg::DataBits-1:0]     write_address_o,
  output logic [rpwe_pkg::DataBits-1:0]     write_data_o,
  output logic [rpwe_pkg::BytesBits-1:0]    write_bytes_o,
  output logic                              done_res_o
);
  import rpwe_pkg::*;

  localparam int unsigned WB = COORD_BITS + 1;                      // walk/pixel coords
  localparam int unsigned SW = (ADDR_BITS > DataBits) ? ADDR_BITS : DataBits;
  localparam int unsigned RB = WB + PitchBits;                      // row offset width
  localparam int unsigned CB = WB + BytesBits;                      // column offset width
  localparam int unsigned KB = (WB > ScreenBits) ? WB : ScreenBits; // clip compare width
  localparam logic [SW-1:0] ADDR_MASK = {SW{1'b1}} >> (SW - ADDR_BITS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FbBaseBits-1:0] fb_base_q;
  logic [ScreenBits-1:0] screen_width_q, screen_height_q;
  logic [PitchBits-1:0]  line_pitch_q;
  logic [FormatBits-1:0] pixel_format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q       <= FB_BASE_RST;
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
      line_pitch_q    <= LINE_PITCH_RST;
      pixel_format_q  <= FMT_RGB565;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FB_BASE:       fb_base_q       <= cfg_data_i[FbBaseBits-1:0];
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[ScreenBits-1:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[ScreenBits-1:0];
        CFG_LINE_PITCH:    line_pitch_q    <= cfg_data_i[PitchBits-1:0];
        CFG_PIXEL_FORMAT:  pixel_format_q  <= cfg_data_i[FormatBits-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic s2_advance, s1_advance, in_accept;

  assign s2_advance = out_ready_i || !out_valid_o;
  assign s1_advance = s1_valid_q && s2_advance;
  assign in_ready_o = !s1_valid_q || s2_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Rectangle walk state
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] origin_col_q, origin_row_q, span_cols_q, span_rows_q;
  logic [DataBits-1:0]   packed_colour_q;
  logic                  fill_flag_q, active_q;
  logic [WB-1:0]         walk_col_q, walk_row_q;
  logic [1:0]            phase_q;

  logic [COORD_BITS-1:0] origin_col_d, origin_row_d, span_cols_d, span_rows_d;
  logic [DataBits-1:0]   packed_colour_d;
  logic                  fill_flag_d, active_d;
  logic [WB-1:0]         walk_col_d, walk_row_d;
  logic [1:0]            phase_d;

  logic [WB-1:0] col_first, col_last, row_first, row_last, col_walk, row_walk;
  logic          col_end, row_end;
  logic [WB-1:0] cand_col, cand_row;
  logic          cand, last;

  // Candidate pixel and next walk state for the current request
  always_comb begin
    col_walk  = WB'(origin_col_q) + walk_col_q;
    row_walk  = WB'(origin_row_q) + walk_row_q;
    col_first = WB'(origin_col_q);
    row_first = WB'(origin_row_q);
    col_last  = WB'(origin_col_q) + WB'(span_cols_q) - WB'(1);
    row_last  = WB'(origin_row_q) + WB'(span_rows_q) - WB'(1);
    col_end   = (walk_col_q + WB'(1)) >= WB'(span_cols_q);
    row_end   = (walk_row_q + WB'(1)) >= WB'(span_rows_q);

    origin_col_d    = origin_col_q;
    origin_row_d    = origin_row_q;
    span_cols_d     = span_cols_q;
    span_rows_d     = span_rows_q;
    packed_colour_d = packed_colour_q;
    fill_flag_d     = fill_flag_q;
    active_d        = active_q;
    walk_col_d      = walk_col_q;
    walk_row_d      = walk_row_q;
    phase_d         = phase_q;
    cand_col        = col_walk;
    cand_row        = row_walk;
    cand            = 1'b0;
    last            = 1'b0;

    if (mode_i == MODE_START) begin
      // Latch a new rectangle; empty ones leave the engine idle
      origin_col_d    = rect_x_i;
      origin_row_d    = rect_y_i;
      span_cols_d     = rect_w_i;
      span_rows_d     = rect_h_i;
      packed_colour_d = pack_colour(pixel_format_q, red_i, green_i, blue_i, alpha_i);
      fill_flag_d     = filled_i;
      walk_col_d      = '0;
      walk_row_d      = '0;
      phase_d         = PH_TOP;
      active_d        = (rect_w_i != '0) && (rect_h_i != '0);
    end else if (active_q) begin
      cand = 1'b1;
      if (fill_flag_q) begin
        // Filled: raster order
        if (col_end) begin
          walk_col_d = '0;
          if (row_end) last = 1'b1;
          else         walk_row_d = walk_row_q + WB'(1);
        end else begin
          walk_col_d = walk_col_q + WB'(1);
        end
      end else begin
        // Outline: top/bottom per column, then left/right per row
        unique case (phase_q)
          PH_TOP: begin
            cand_row = row_first;
            phase_d  = PH_BOTTOM;
          end
          PH_BOTTOM: begin
            cand_row = row_last;
            if (col_end) begin
              walk_col_d = '0;
              phase_d    = PH_LEFT;
            end else begin
              walk_col_d = walk_col_q + WB'(1);
              phase_d    = PH_TOP;
            end
          end
          PH_LEFT: begin
            cand_col = col_first;
            phase_d  = PH_RIGHT;
          end
          default: begin
            cand_col = col_last;
            if (row_end) begin
              last = 1'b1;
            end else begin
              walk_row_d = walk_row_q + WB'(1);
              phase_d    = PH_LEFT;
            end
          end
        endcase
      end
      if (last) begin
        active_d   = 1'b0;
        walk_col_d = '0;
        walk_row_d = '0;
        phase_d    = PH_TOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q    <= '0;
      origin_row_q    <= '0;
      span_cols_q     <= '0;
      span_rows_q     <= '0;
      packed_colour_q <= '0;
      fill_flag_q     <= 1'b0;
      active_q        <= 1'b0;
      walk_col_q      <= '0;
      walk_row_q      <= '0;
      phase_q         <= PH_TOP;
    end else if (in_accept) begin
      origin_col_q    <= origin_col_d;
      origin_row_q    <= origin_row_d;
      span_cols_q     <= span_cols_d;
      span_rows_q     <= span_rows_d;
      packed_colour_q <= packed_colour_d;
      fill_flag_q     <= fill_flag_d;
      active_q        <= active_d;
      walk_col_q      <= walk_col_d;
      walk_row_q      <= walk_row_d;
      phase_q         <= phase_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: candidate register
  // --------------------------------------------------------------------------
  logic                s1_cand_q, s1_done_q;
  logic [WB-1:0]       s1_col_q, s1_row_q;
  logic [DataBits-1:0] s1_colour_q;
  logic                done_d;

  always_comb begin
    if (mode_i == MODE_START) done_d = !active_d;
    else if (!active_q)       done_d = 1'b1;
    else                      done_d = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cand_q   <= cand;
      s1_done_q   <= done_d;
      s1_col_q    <= cand_col;
      s1_row_q    <= cand_row;
      s1_colour_q <= packed_colour_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clip and address into the output register
  // --------------------------------------------------------------------------
  logic [BytesBits-1:0] nb;
  logic [RB-1:0]        row_off;
  logic [CB-1:0]        col_off;
  logic [SW-1:0]        addr_sum;
  logic                 visible;

  assign nb       = bytes_of(pixel_format_q);
  assign row_off  = RB'(s1_row_q) * RB'(line_pitch_q);
  assign col_off  = CB'(s1_col_q) * CB'(nb);
  assign addr_sum = (SW'(fb_base_q) + SW'(row_off) + SW'(col_off)) & ADDR_MASK;
  assign visible  = s1_cand_q && (KB'(s1_col_q) < KB'(screen_width_q))
                    && (KB'(s1_row_q) < KB'(screen_height_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      write_valid_o   <= visible;
      write_address_o <= visible ? addr_sum[DataBits-1:0] : '0;
      write_data_o    <= visible ? s1_colour_q : '0;
      write_bytes_o   <= visible ? nb : '0;
      done_res_o      <= s1_done_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> (write_bytes_o == '0) && (write_address_o == '0)
                                      && (write_data_o == '0))
    else $error("suppressed write carries nonzero payload");

  a_write_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> (write_bytes_o != '0))
    else $error("visible write with zero byte count");

  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (mode_i == MODE_START) && ((rect_w_i == '0) || (rect_h_i == '0))
      |=> !active_q)
    else $error("empty rectangle left engine active");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without downstream backpressure");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rectangle pixel write engine. A stimulus
// process fills a queue of requests (directed cases, then random rectangle
// walks); a clocked driver offers them, a clocked monitor predicts every
// result at acceptance and compares each returned result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rpwe_pkg::*;

  localparam int unsigned CW = CoordBitsDefault;
  // Format code outside the defined set, packs as rgb888
  localparam logic [FormatBits-1:0] FMT_UNKNOWN7 = 3'd7;

  typedef struct packed {
    logic          mode;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic [7:0]    a;
    logic          filled;
  } pix_req_t;

  typedef struct packed {
    logic        wv;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        done;
  } pix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we_i = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0]  cfg_data_i = '0;

  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  pix_req_t cur_req = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  logic     write_valid_o;
  logic [DataBits-1:0]  write_address_o;
  logic [DataBits-1:0]  write_data_o;
  logic [BytesBits-1:0] write_bytes_o;
  logic     done_res_o;

  rectangle_pixel_write_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (cur_req.mode),
    .rect_x_i       (cur_req.x),
    .rect_y_i       (cur_req.y),
    .rect_w_i       (cur_req.w),
    .rect_h_i       (cur_req.h),
    .red_i          (cur_req.r),
    .green_i        (cur_req.g),
    .blue_i         (cur_req.b),
    .alpha_i        (cur_req.a),
    .filled_i       (cur_req.filled),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_valid_o  (write_valid_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .write_bytes_o  (write_bytes_o),
    .done_res_o     (done_res_o)
  );

  // Request queue, expected results, counters
  pix_req_t pending_reqs[$];
  pix_res_t expected_writes[$];
  pix_res_t want;
  bit       req_taken = 1'b0;
  int       send_idle_pct = 9;
  int       recv_idle_pct = 60;
  int       rx_hold_req = 0;
  int       rx_hold_left = 0;
  int       n_errors = 0;
  int       n_reqs = 0;
  int       n_pixels = 0;

  // Register shadows
  logic [31:0]           fb_reg;
  logic [11:0]           scr_w;
  logic [11:0]           scr_h;
  logic [13:0]           pitch_reg;
  logic [FormatBits-1:0] fmt_reg;

  // Walker state
  logic [CW-1:0] org_col;
  logic [CW-1:0] org_row;
  logic [CW-1:0] span_c;
  logic [CW-1:0] span_r;
  logic [31:0]   pix_word;
  logic          fill_mode;
  logic [CW:0]   walk_c;
  logic [CW:0]   walk_r;
  logic [1:0]    phase;
  logic          busy;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("[%0t] MISMATCH %s: got %0h expected %0h", $realtime, what, got, exp);
    n_errors++;
  endtask

  // Predict the result of one accepted request and advance the walker
  function automatic pix_res_t compute_pixel_write(input pix_req_t rq);
    pix_res_t    res;
    int unsigned col;
    int unsigned row;
    int unsigned nb;
    bit          last;
    logic [63:0] addr;
    res  = '0;
    col  = 0;
    row  = 0;
    last = 1'b0;
    if (rq.mode == MODE_START) begin
      org_col   = rq.x;
      org_row   = rq.y;
      span_c    = rq.w;
      span_r    = rq.h;
      fill_mode = rq.filled;
      case (fmt_reg)
        FMT_INDEXED8: pix_word = {24'd0, rq.b};
        FMT_RGB555: pix_word = ((32'(rq.r) >> 3) << 10) | ((32'(rq.g) >> 3) << 5)
                               | (32'(rq.b) >> 3);
        FMT_RGB565: pix_word = ((32'(rq.r) >> 3) << 11) | ((32'(rq.g) >> 2) << 5)
                               | (32'(rq.b) >> 3);
        FMT_RGBA8888: pix_word = {rq.a, rq.r, rq.g, rq.b};
        default: pix_word = {8'd0, rq.r, rq.g, rq.b};
      endcase
      walk_c   = '0;
      walk_r   = '0;
      phase    = PH_TOP;
      busy     = (span_c != 0) && (span_r != 0);
      res.done = !busy;
      return res;
    end
    if (!busy) begin
      res.done = 1'b1;
      return res;
    end
    if (fill_mode) begin
      // Row by row, left to right
      col = org_col + walk_c;
      row = org_row + walk_r;
      if (walk_c + 1 >= span_c) begin
        walk_c = '0;
        if (walk_r + 1 >= span_r) last = 1'b1;
        else walk_r++;
      end else begin
        walk_c++;
      end
    end else begin
      // Outline: top/bottom per column, then left/right per row
      case (phase)
        PH_TOP: begin
          col   = org_col + walk_c;
          row   = org_row;
          phase = PH_BOTTOM;
        end
        PH_BOTTOM: begin
          col = org_col + walk_c;
          row = org_row + span_r - 1;
          if (walk_c + 1 >= span_c) begin
            walk_c = '0;
            phase  = PH_LEFT;
          end else begin
            walk_c++;
            phase = PH_TOP;
          end
        end
        PH_LEFT: begin
          col   = org_col;
          row   = org_row + walk_r;
          phase = PH_RIGHT;
        end
        default: begin
          col = org_col + span_c - 1;
          row = org_row + walk_r;
          if (walk_r + 1 >= span_r) begin
            last = 1'b1;
          end else begin
            walk_r++;
            phase = PH_LEFT;
          end
        end
      endcase
    end
    // Clip against the screen
    if (col < scr_w && row < scr_h) begin
      case (fmt_reg)
        FMT_INDEXED8: nb = 1;
        FMT_RGB555:   nb = 2;
        FMT_RGB565:   nb = 2;
        FMT_RGBA8888: nb = 4;
        default:      nb = 3;
      endcase
      addr       = 64'(fb_reg) + 64'(row) * 64'(pitch_reg) + 64'(col) * 64'(nb);
      res.wv     = 1'b1;
      res.addr   = addr[31:0];
      res.data   = pix_word;
      res.nbytes = nb[2:0];
    end
    if (last) begin
      busy     = 1'b0;
      walk_c   = '0;
      walk_r   = '0;
      phase    = PH_TOP;
      res.done = 1'b1;
    end
    return res;
  endfunction

  // Request driver: new request only when the line is free or just taken
  always @(negedge clk_i) begin
    if (!in_valid_i || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req    <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check results, then predict newly accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("result with nothing pending", write_address_o, 0);
        end else begin
          want = expected_writes.pop_front();
          if (write_valid_o !== want.wv)
            report_mismatch("write_valid", write_valid_o, want.wv);
          if (write_address_o !== want.addr)
            report_mismatch("write_address", write_address_o, want.addr);
          if (write_data_o !== want.data)
            report_mismatch("write_data", write_data_o, want.data);
          if (write_bytes_o !== want.nbytes)
            report_mismatch("write_bytes", write_bytes_o, want.nbytes);
          if (done_res_o !== want.done)
            report_mismatch("done_res", done_res_o, want.done);
          if (want.wv) n_pixels++;
        end
      end
      req_taken = in_valid_i && in_ready_o;
      if (req_taken) begin
        expected_writes.push_back(compute_pixel_write(cur_req));
        n_reqs++;
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FB_BASE:       fb_reg = val;
      CFG_SCREEN_WIDTH:  scr_w = val[11:0];
      CFG_SCREEN_HEIGHT: scr_h = val[11:0];
      CFG_LINE_PITCH:    pitch_reg = val[13:0];
      CFG_PIXEL_FORMAT:  fmt_reg = val[FormatBits-1:0];
      default: ;
    endcase
  endtask

  task automatic setup_screen(input logic [31:0] base, input int w, input int h,
                              input int pitch, input logic [FormatBits-1:0] fmt);
    write_reg(CFG_FB_BASE, base);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_LINE_PITCH, pitch);
    write_reg(CFG_PIXEL_FORMAT, 32'(fmt));
  endtask

  // Wait until every request is taken and every result is back
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_writes.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_start(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] w, input logic [CW-1:0] h,
                             input logic fill, input logic [31:0] rgba);
    pix_req_t rq;
    rq        = '0;
    rq.mode   = MODE_START;
    rq.x      = x;
    rq.y      = y;
    rq.w      = w;
    rq.h      = h;
    {rq.r, rq.g, rq.b, rq.a} = rgba;
    rq.filled = fill;
    pending_reqs.push_back(rq);
  endtask

  // Step requests carry random junk in the unused fields
  task automatic queue_steps(input int n);
    pix_req_t    rq;
    logic [95:0] junk;
    for (int i = 0; i < n; i++) begin
      junk    = {$urandom(), $urandom(), $urandom()};
      rq      = junk[$bits(pix_req_t)-1:0];
      rq.mode = MODE_STEP;
      pending_reqs.push_back(rq);
    end
  endtask

  // Origin inside, near the clipping edge, or anywhere
  function automatic logic [CW-1:0] pick_coord(input logic [11:0] lim);
    case ($urandom_range(2))
      0: return CW'($urandom_range(4095));
      1: return CW'(int'(lim) + int'($urandom_range(8)) - 4);
      default: return CW'($urandom_range(int'(lim)));
    endcase
  endfunction

  // Mostly complete walks of small rectangles, some cut short, some noise
  task automatic queue_random(input int n);
    int cnt;
    int kind;
    int w;
    int h;
    int steps;
    bit fl;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        w  = ($urandom_range(7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        h  = ($urandom_range(7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        fl = 1'($urandom_range(1));
        queue_start(pick_coord(scr_w), pick_coord(scr_h), CW'(w), CW'(h), fl, $urandom());
        steps = fl ? w * h : 2 * (w + h);
        if ($urandom_range(9) == 0) steps = $urandom_range(steps);
        queue_steps(steps);
        cnt += steps + 1;
      end else if (kind < 92) begin
        // Huge or empty rectangle, abandoned after a few steps
        w     = ($urandom_range(3) == 0) ? 0 : $urandom_range(4095);
        h     = ($urandom_range(3) == 0) ? 0 : $urandom_range(4095);
        queue_start(CW'($urandom_range(4095)), CW'($urandom_range(4095)), CW'(w), CW'(h),
                    1'($urandom_range(1)), $urandom());
        steps = $urandom_range(1, 4);
        queue_steps(steps);
        cnt += steps + 1;
      end else begin
        steps = $urandom_range(1, 3);
        queue_steps(steps);
        cnt += steps;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    fb_reg    = FB_BASE_RST;
    scr_w     = SCREEN_WIDTH_RST;
    scr_h     = SCREEN_HEIGHT_RST;
    pitch_reg = LINE_PITCH_RST;
    fmt_reg   = FMT_RGB565;
    org_col   = '0;
    org_row   = '0;
    span_c    = '0;
    span_r    = '0;
    pix_word  = '0;
    fill_mode = 1'b0;
    walk_c    = '0;
    walk_r    = '0;
    phase     = PH_TOP;
    busy      = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed cases at reset configuration
    send_idle_pct = 9;
    recv_idle_pct = 60;
    queue_steps(1);                                    // step with no rectangle
    queue_start(10, 10, 0, 5, 1'b1, 32'hFFFF_FFFF);    // zero width
    queue_start(10, 10, 5, 0, 1'b0, 32'h0000_0000);    // zero height
    queue_start(0, 0, 2, 2, 1'b1, 32'hFFFF_FFFF);      // small fill at origin
    queue_steps(4);
    queue_start(1023, 767, 1, 1, 1'b0, 32'h8040_2010);  // single pixel outline
    queue_steps(4);
    queue_start(4095, 4095, 4095, 4095, 1'b1, 32'h1234_5678); // fully clipped
    queue_steps(2);
    queue_start(1022, 766, 3, 2, 1'b0, 32'hA5C3_7E01);  // outline over the edge
    queue_steps(3);
    drain();
    // Format changes while the outline is half walked
    write_reg(CFG_PIXEL_FORMAT, 32'(FMT_INDEXED8));
    queue_steps(7);
    drain();

    // Small screen, rgb555; sender idles rarely, receiver often
    setup_screen($urandom(), 64, 48, 256, FMT_RGB555);
    queue_random(600);
    drain();

    // Largest screen and pitch, wrapping base, rgba8888; idling swapped
    send_idle_pct = 60;
    recv_idle_pct = 9;
    setup_screen(32'hFFFF_FFF0, 4095, 4095, 16383, FMT_RGBA8888);
    queue_random(600);
    drain();

    // No idling: zero-size screen with an unknown format
    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup_screen(32'h0000_0000, 0, 0, 0, FMT_UNKNOWN7);
    queue_random(200);
    drain();

    // rgb888; long output stall while the sender keeps pushing
    setup_screen($urandom(), 640, 480, 2560, FMT_RGB888);
    rx_hold_req = 400;
    queue_random(150);
    drain();
    queue_random(300);
    drain();

    repeat (6) @(posedge clk_i);
    if (expected_writes.size() != 0)
      report_mismatch("results never returned", expected_writes.size(), 0);
    $display("Run covered %0d requests and %0d pixel writes over all pixel formats,",
             n_reqs, n_pixels);
    $display("fill and outline walks with clipping, and mixed or stalled handshakes.");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
